### rtl/bfd_pkg.sv
// shared types and constants of the box filter downscaler
package bfd_pkg;

	localparam int PIX_W  = 8;
	localparam int NCH    = 4;
	localparam int SUM_W  = 20;
	localparam int DIV_W  = 14;
	localparam int SCL_W  = 7;
	localparam int SRCW_W = 13;
	localparam int DIM_W  = 8;
	localparam int ROW_W  = 7;
	localparam int POS_W  = 7;
	localparam int CMP_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

	typedef logic [SUM_W-1:0] sum_t;
	typedef sum_t [NCH-1:0] sum4_t;
	typedef logic [DIV_W-1:0] rem_t;
	typedef rem_t [NCH-1:0] rem4_t;

	typedef struct packed {
		logic             frame_start;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] alpha;
	} pix_word_t;

	typedef struct packed {
		logic [POS_W-1:0] out_x;
		logic [POS_W-1:0] out_y;
		logic [PIX_W-1:0] avg_blue;
		logic [PIX_W-1:0] avg_green;
		logic [PIX_W-1:0] avg_red;
		logic [PIX_W-1:0] avg_alpha;
		logic             frame_last;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESYNC,
		ST_RMW,
		ST_DIV,
		ST_OUT
	} st_t;

endpackage

### rtl/box_filter_image_downscaler.sv
// box filter image downscaler top level: counters, line store access, result register
// a word that does not finish a block is accepted, then read-modify-written
// a word that finishes a block then also runs the 20 step serial divider;
// its result is loaded onto res once the result register is free
// a scale write recomputes the block position with the same divider, pix_ready low
// reset clears counters and loads register defaults; the line store is not cleared
module box_filter_image_downscaler #(
	parameter int MAX_OUT_WIDTH  = 128,
	parameter int MAX_OUT_HEIGHT = 128,
	parameter int MAX_SCALE      = 64,
	parameter int MAX_SRC_WIDTH  = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// source pixel words
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  bfd_pkg::pix_word_t              pix,
	// averaged result words
	output logic                            res_valid,
	input  logic                            res_ready,
	output bfd_pkg::res_word_t              res,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// effective limits, bounded by what the register widths can hold
	localparam int SCL_LIM  = (MAX_SCALE > 127) ? 127 : MAX_SCALE;
	localparam int SRCW_LIM = (MAX_SRC_WIDTH > 8191) ? 8191 : MAX_SRC_WIDTH;
	localparam int OW_LIM   = (MAX_OUT_WIDTH > 255) ? 255 : MAX_OUT_WIDTH;
	localparam int OH_LIM   = (MAX_OUT_HEIGHT > 255) ? 255 : MAX_OUT_HEIGHT;
	// source column never reaches the source width
	localparam int COL_W    = (SRCW_LIM > 1) ? $clog2(SRCW_LIM) : 1;
	localparam int RAM_AW   = (OW_LIM > 1) ? $clog2(OW_LIM) : 1;
	localparam int CW       = bfd_pkg::CMP_W;

	// configuration registers
	logic [bfd_pkg::SCL_W-1:0]  scale_q;
	logic [bfd_pkg::SRCW_W-1:0] src_width_q;
	logic [bfd_pkg::DIM_W-1:0]  out_width_q;
	logic [bfd_pkg::DIM_W-1:0]  out_height_q;
	logic                       resync_q;

	// clamped register values
	logic [bfd_pkg::SCL_W-1:0]  s_eff;
	logic [bfd_pkg::SRCW_W-1:0] sw_eff;
	logic [bfd_pkg::DIM_W-1:0]  ow_eff;
	logic [bfd_pkg::DIM_W-1:0]  oh_eff;
	logic [bfd_pkg::DIV_W-1:0]  blk_area;

	// position counters: block column and column in block track src col
	logic [COL_W-1:0]           col_q;
	logic [COL_W-1:0]           bx_q;
	logic [bfd_pkg::SCL_W-1:0]  cib_q;
	logic [bfd_pkg::ROW_W-1:0]  rib_q;
	logic [bfd_pkg::DIM_W-1:0]  orow_q;

	// position of the word in flight
	logic [COL_W-1:0]           col_s1;
	logic [COL_W-1:0]           bx_s1;
	logic [bfd_pkg::SCL_W-1:0]  cib_s1;
	logic [bfd_pkg::ROW_W-1:0]  rib_s1;
	logic [bfd_pkg::DIM_W-1:0]  orow_s1;
	logic [bfd_pkg::NCH-1:0][bfd_pkg::PIX_W-1:0] ch_s1;

	// result coordinates waiting for the divider
	logic [bfd_pkg::POS_W-1:0]  ox_s2;
	logic [bfd_pkg::POS_W-1:0]  oy_s2;
	logic                       last_s2;

	bfd_pkg::st_t               state_q;
	bfd_pkg::st_t               state_nx;

	logic                       pix_acc;
	logic                       res_load;
	logic                       res_valid_q;
	bfd_pkg::res_word_t         res_q;

	// line store
	logic                       ram_we;
	logic [RAM_AW-1:0]          ram_raddr;
	logic [RAM_AW-1:0]          ram_waddr;
	bfd_pkg::sum4_t             ram_rdata;
	bfd_pkg::sum4_t             sum_new;

	// divider
	logic                       div_start;
	logic                       div_done;
	bfd_pkg::sum4_t             div_dvd;
	logic [bfd_pkg::DIV_W-1:0]  div_dvs;
	bfd_pkg::sum4_t             div_quot;
	bfd_pkg::rem4_t             div_rem;

	// read-modify-write decisions
	logic                       blk_act;
	logic                       blk_first;
	logic                       blk_emit;
	logic                       col_wrap;
	logic                       row_wrap;
	logic                       cib_wrap;

	// zero reads as one, oversize saturates
	always_comb begin
		if (scale_q == '0) begin
			s_eff = bfd_pkg::SCL_W'(1);
		end else if (32'(scale_q) > 32'(SCL_LIM)) begin
			s_eff = bfd_pkg::SCL_W'(SCL_LIM);
		end else begin
			s_eff = scale_q;
		end
		if (src_width_q == '0) begin
			sw_eff = bfd_pkg::SRCW_W'(1);
		end else if (32'(src_width_q) > 32'(SRCW_LIM)) begin
			sw_eff = bfd_pkg::SRCW_W'(SRCW_LIM);
		end else begin
			sw_eff = src_width_q;
		end
		if (out_width_q == '0) begin
			ow_eff = bfd_pkg::DIM_W'(1);
		end else if (32'(out_width_q) > 32'(OW_LIM)) begin
			ow_eff = bfd_pkg::DIM_W'(OW_LIM);
		end else begin
			ow_eff = out_width_q;
		end
		if (out_height_q == '0) begin
			oh_eff = bfd_pkg::DIM_W'(1);
		end else if (32'(out_height_q) > 32'(OH_LIM)) begin
			oh_eff = bfd_pkg::DIM_W'(OH_LIM);
		end else begin
			oh_eff = out_height_q;
		end
	end

	// pixels per block, the divisor of every mean
	assign blk_area = bfd_pkg::DIV_W'(s_eff) * bfd_pkg::DIV_W'(s_eff);

	assign cfg_ready = 1'b1;
	assign pix_acc   = pix_valid && pix_ready;

	// register writes; a scale change asks for the block position to be recomputed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= bfd_pkg::SCL_W'(1);
			src_width_q  <= bfd_pkg::SRCW_W'(128);
			out_width_q  <= bfd_pkg::DIM_W'(128);
			out_height_q <= bfd_pkg::DIM_W'(128);
			resync_q     <= 1'b0;
		end else begin
			if (state_q == bfd_pkg::ST_IDLE && resync_q) begin
				resync_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bfd_pkg::CFG_SCALE: begin
						scale_q  <= cfg_data[bfd_pkg::SCL_W-1:0];
						resync_q <= 1'b1;
					end
					bfd_pkg::CFG_SRC_WIDTH: begin
						src_width_q <= cfg_data[bfd_pkg::SRCW_W-1:0];
					end
					bfd_pkg::CFG_OUT_WIDTH: begin
						out_width_q <= cfg_data[bfd_pkg::DIM_W-1:0];
					end
					bfd_pkg::CFG_OUT_HEIGHT: begin
						out_height_q <= cfg_data[bfd_pkg::DIM_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// block decisions for the word in flight
	assign blk_act   = (CW'(orow_s1) < CW'(oh_eff)) && (CW'(bx_s1) < CW'(ow_eff));
	assign blk_first = (rib_s1 == '0) && (cib_s1 == '0);
	assign row_wrap  = (CW'(rib_s1) + CW'(1)) >= CW'(s_eff);
	assign cib_wrap  = (CW'(cib_s1) + CW'(1)) == CW'(s_eff);
	assign col_wrap  = (CW'(col_s1) + CW'(1)) >= CW'(sw_eff);
	assign blk_emit  = blk_act && row_wrap && cib_wrap;

	// top-left pixel of a block overwrites its slot, others add
	always_comb begin
		for (int c = 0; c < bfd_pkg::NCH; c++) begin
			if (blk_first) begin
				sum_new[c] = bfd_pkg::SUM_W'(ch_s1[c]);
			end else begin
				sum_new[c] = ram_rdata[c] + bfd_pkg::SUM_W'(ch_s1[c]);
			end
		end
	end

	// read address: frame start puts the word at block column zero
	assign ram_raddr = pix.frame_start ? '0 : RAM_AW'(bx_q);
	assign ram_waddr = RAM_AW'(bx_s1);
	assign ram_we    = (state_q == bfd_pkg::ST_RMW) && blk_act;

	bfd_ram #(
		.WIDTH ($bits(bfd_pkg::sum4_t)),
		.DEPTH (OW_LIM)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sum_new),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// divider serves both the block means and the column position after a scale change
	always_comb begin
		if (state_q == bfd_pkg::ST_RMW) begin
			div_dvd = sum_new;
			div_dvs = blk_area;
		end else begin
			div_dvd    = '0;
			div_dvd[0] = bfd_pkg::SUM_W'(col_q);
			div_dvs    = bfd_pkg::DIV_W'(s_eff);
		end
	end

	bfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		pix_ready = 1'b0;
		div_start = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			bfd_pkg::ST_IDLE: begin
				if (resync_q) begin
					div_start = 1'b1;
					state_nx  = bfd_pkg::ST_RESYNC;
				end else begin
					pix_ready = 1'b1;
					if (pix_valid) begin
						state_nx = bfd_pkg::ST_RMW;
					end
				end
			end
			bfd_pkg::ST_RESYNC: begin
				if (div_done) begin
					state_nx = bfd_pkg::ST_IDLE;
				end
			end
			bfd_pkg::ST_RMW: begin
				if (blk_emit) begin
					div_start = 1'b1;
					state_nx  = bfd_pkg::ST_DIV;
				end else begin
					state_nx = bfd_pkg::ST_IDLE;
				end
			end
			bfd_pkg::ST_DIV: begin
				if (div_done) begin
					state_nx = bfd_pkg::ST_OUT;
				end
			end
			bfd_pkg::ST_OUT: begin
				// wait for the result register to free up
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_nx = bfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bfd_pkg::ST_IDLE;
			end
		endcase
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			bx_q   <= '0;
			cib_q  <= '0;
			rib_q  <= '0;
			orow_q <= '0;
		end else if (state_q == bfd_pkg::ST_RESYNC && div_done) begin
			// remainder is below scale, quotient at most the column
			bx_q  <= COL_W'(div_quot[0]);
			cib_q <= div_rem[0][bfd_pkg::SCL_W-1:0];
		end else if (state_q == bfd_pkg::ST_RMW) begin
			if (col_wrap) begin
				col_q <= '0;
				bx_q  <= '0;
				cib_q <= '0;
				if (row_wrap) begin
					rib_q <= '0;
					if (CW'(orow_s1) < CW'(oh_eff)) begin
						orow_q <= orow_s1 + bfd_pkg::DIM_W'(1);
					end else begin
						orow_q <= orow_s1;
					end
				end else begin
					rib_q  <= rib_s1 + bfd_pkg::ROW_W'(1);
					orow_q <= orow_s1;
				end
			end else begin
				col_q  <= col_s1 + COL_W'(1);
				rib_q  <= rib_s1;
				orow_q <= orow_s1;
				if (cib_wrap) begin
					cib_q <= '0;
					bx_q  <= bx_s1 + COL_W'(1);
				end else begin
					cib_q <= cib_s1 + bfd_pkg::SCL_W'(1);
					bx_q  <= bx_s1;
				end
			end
		end
	end

	// word capture; frame start clears the position it is used at
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			ch_s1 <= {pix.alpha, pix.red, pix.green, pix.blue};
			if (pix.frame_start) begin
				col_s1  <= '0;
				bx_s1   <= '0;
				cib_s1  <= '0;
				rib_s1  <= '0;
				orow_s1 <= '0;
			end else begin
				col_s1  <= col_q;
				bx_s1   <= bx_q;
				cib_s1  <= cib_q;
				rib_s1  <= rib_q;
				orow_s1 <= orow_q;
			end
		end
		if (state_q == bfd_pkg::ST_RMW && blk_emit) begin
			ox_s2   <= bfd_pkg::POS_W'(bx_s1);
			oy_s2   <= bfd_pkg::POS_W'(orow_s1);
			last_s2 <= ((CW'(bx_s1) + CW'(1)) == CW'(ow_eff)) &&
				((CW'(orow_s1) + CW'(1)) == CW'(oh_eff));
		end
	end

	// result register parts the divider from the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.out_x      <= ox_s2;
			res_q.out_y      <= oy_s2;
			res_q.avg_blue   <= div_quot[0][bfd_pkg::PIX_W-1:0];
			res_q.avg_green  <= div_quot[1][bfd_pkg::PIX_W-1:0];
			res_q.avg_red    <= div_quot[2][bfd_pkg::PIX_W-1:0];
			res_q.avg_alpha  <= div_quot[3][bfd_pkg::PIX_W-1:0];
			res_q.frame_last <= last_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/bfd_ram.sv
// generic simple dual port ram with registered read
module bfd_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/bfd_div.sv
// four lane restoring divider, one quotient bit per cycle, shared divisor
module bfd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bfd_pkg::sum4_t              dividend,
	input  logic [bfd_pkg::DIV_W-1:0]   divisor,
	output logic                        done,
	output bfd_pkg::sum4_t              quot,
	output bfd_pkg::rem4_t              rem
);

	localparam int CNT_W = $clog2(bfd_pkg::SUM_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [bfd_pkg::DIV_W-1:0] dvs_q;
	bfd_pkg::sum4_t            quo_q;
	bfd_pkg::rem4_t            rem_q;
	bfd_pkg::sum4_t            quo_nx;
	bfd_pkg::rem4_t            rem_nx;

	// one restoring step per lane
	always_comb begin
		logic [bfd_pkg::DIV_W:0] trial;
		for (int c = 0; c < bfd_pkg::NCH; c++) begin
			trial = {rem_q[c], quo_q[c][bfd_pkg::SUM_W-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_nx[c] = bfd_pkg::DIV_W'(trial - {1'b0, dvs_q});
				quo_nx[c] = {quo_q[c][bfd_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_nx[c] = trial[bfd_pkg::DIV_W-1:0];
				quo_nx[c] = {quo_q[c][bfd_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(bfd_pkg::SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

### bench/tb_box_filter_image_downscaler.sv
// testbench for the box filter image downscaler: directed and random streams against a predictor
`timescale 1ns / 100ps

module tb_box_filter_image_downscaler;

	// block limits, passed to the instance as well
	localparam int SCALE_MAX   = 64;
	localparam int SRC_W_MAX   = 4096;
	localparam int OUT_W_MAX   = 128;
	localparam int OUT_H_MAX   = 128;
	// drain wait for the slowest word, from acceptance to its averaged word
	localparam int SETTLE_CYC  = 30;
	// cycles with no handshake at all before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_WORDS  = 800;

	logic                           clk;
	logic                           arst_n;
	logic                           pix_valid;
	logic                           pix_ready;
	bfd_pkg::pix_word_t             pix;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	bfd_pkg::res_word_t             res;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the registers, at their reset values
	logic [bfd_pkg::SCL_W-1:0]  scale_reg = bfd_pkg::SCL_W'(1);
	logic [bfd_pkg::SRCW_W-1:0] src_w_reg = bfd_pkg::SRCW_W'(128);
	logic [bfd_pkg::DIM_W-1:0]  out_w_reg = bfd_pkg::DIM_W'(128);
	logic [bfd_pkg::DIM_W-1:0]  out_h_reg = bfd_pkg::DIM_W'(128);

	// predictor copy of the line store and position counters
	bfd_pkg::sum4_t line_sum [OUT_W_MAX];
	int unsigned    src_col   = 0;
	int unsigned    blk_row   = 0;
	int unsigned    thumb_row = 0;

	// averaged words still owed by the block, oldest first
	bfd_pkg::res_word_t thumb_q [$];
	bfd_pkg::res_word_t due_word;
	int unsigned fail_count   = 0;
	int unsigned ready_hold   = 0;
	int unsigned quiet_cycles = 0;
	// no idling on either side while set
	bit          calm = 1'b0;

	box_filter_image_downscaler #(
		.MAX_OUT_WIDTH (OUT_W_MAX),
		.MAX_OUT_HEIGHT(OUT_H_MAX),
		.MAX_SCALE     (SCALE_MAX),
		.MAX_SRC_WIDTH (SRC_W_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// zero means 1, anything past the limit saturates
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bfd_pkg::pix_word_t rand_pixel(input logic fs);
		bfd_pkg::pix_word_t p;
		p = {1'b0, 32'($urandom)};   // fills all four channels
		p.frame_start = fs;
		return p;
	endfunction

	// advance the predictor by one accepted source word
	task automatic downscale_pixel(input bfd_pkg::pix_word_t w);
		int unsigned                s, sw, ow, oh, bx, cib, area;
		logic [bfd_pkg::PIX_W-1:0]  chan [bfd_pkg::NCH];
		bfd_pkg::res_word_t         avg_word;
		s  = clamp_dim(32'(scale_reg), SCALE_MAX);
		sw = clamp_dim(32'(src_w_reg), SRC_W_MAX);
		ow = clamp_dim(32'(out_w_reg), OUT_W_MAX);
		oh = clamp_dim(32'(out_h_reg), OUT_H_MAX);
		chan[0] = w.blue;
		chan[1] = w.green;
		chan[2] = w.red;
		chan[3] = w.alpha;
		// a frame start clears the counters before the word is used
		if (w.frame_start) begin
			src_col   = 0;
			blk_row   = 0;
			thumb_row = 0;
		end
		bx  = src_col / s;
		cib = src_col % s;
		// words right of the last block or below the last band are dropped
		if (thumb_row < oh && bx < ow) begin
			for (int c = 0; c < bfd_pkg::NCH; c++) begin
				// top-left word of a block overwrites its slot, the rest accumulate
				line_sum[bx][c] = (blk_row == 0 && cib == 0) ? bfd_pkg::sum_t'(chan[c]) :
					bfd_pkg::sum_t'(line_sum[bx][c] + chan[c]);
			end
			// bottom-right word of the block closes it
			if (blk_row + 1 >= s && cib + 1 == s) begin
				area = s * s;
				avg_word.out_x      = bfd_pkg::POS_W'(bx);
				avg_word.out_y      = bfd_pkg::POS_W'(thumb_row);
				avg_word.avg_blue   = bfd_pkg::PIX_W'(line_sum[bx][0] / area);
				avg_word.avg_green  = bfd_pkg::PIX_W'(line_sum[bx][1] / area);
				avg_word.avg_red    = bfd_pkg::PIX_W'(line_sum[bx][2] / area);
				avg_word.avg_alpha  = bfd_pkg::PIX_W'(line_sum[bx][3] / area);
				avg_word.frame_last = (bx + 1 == ow && thumb_row + 1 == oh);
				thumb_q.push_back(avg_word);
			end
		end
		// raster walk; the band counter sticks once it reaches the height
		if (src_col + 1 >= sw) begin
			src_col = 0;
			if (blk_row + 1 >= s) begin
				blk_row = 0;
				if (thumb_row < oh) begin
					thumb_row++;
				end
			end else begin
				blk_row++;
			end
		end else begin
			src_col++;
		end
	endtask

	// all tasks below start and end just after a falling edge
	task automatic send_pixel(input bfd_pkg::pix_word_t w);
		// random gap, with junk on the bus while valid is low
		if (!calm && $urandom_range(0, 9) == 0) begin
			pix_valid <= 1'b0;
			pix       <= rand_pixel(1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= w;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		downscale_pixel(w);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [bfd_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= bfd_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bfd_pkg::CFG_SCALE:      scale_reg = bfd_pkg::SCL_W'(val);
			bfd_pkg::CFG_SRC_WIDTH:  src_w_reg = bfd_pkg::SRCW_W'(val);
			bfd_pkg::CFG_OUT_WIDTH:  out_w_reg = bfd_pkg::DIM_W'(val);
			bfd_pkg::CFG_OUT_HEIGHT: out_h_reg = bfd_pkg::DIM_W'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending, collect every owed word, then let the last word drain
	task automatic settle();
		pix_valid <= 1'b0;
		while (thumb_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic set_geometry(input int unsigned s, input int unsigned sw,
		input int unsigned ow, input int unsigned oh);
		settle();
		write_reg(bfd_pkg::CFG_SCALE, s);
		write_reg(bfd_pkg::CFG_SRC_WIDTH, sw);
		write_reg(bfd_pkg::CFG_OUT_WIDTH, ow);
		write_reg(bfd_pkg::CFG_OUT_HEIGHT, oh);
	endtask

	// rows * cols words in raster order; extremes pins blue full, green zero, red alternating
	task automatic send_frame(input int rows, input int cols, input bit restart,
		input bit extremes);
		bfd_pkg::pix_word_t p;
		for (int n = 0; n < rows * cols; n++) begin
			p = rand_pixel(restart && n == 0);
			if (extremes) begin
				p.blue  = 8'hFF;
				p.green = 8'h00;
				p.red   = n[0] ? 8'hFF : 8'h00;
			end
			send_pixel(p);
		end
	endtask

	// reset registers: scale 1, 128 wide, no frame start needed
	task automatic test_reset_defaults();
		send_pixel('0);
		send_pixel({1'b0, 32'hFFFF_FFFF});
		send_pixel({1'b0, 32'hAA55_AA55});
		send_pixel({1'b0, 32'h55AA_55AA});
		// rest of the first row and two words into the second
		for (int n = 0; n < 126; n++) begin
			send_pixel(rand_pixel(1'b0));
		end
	endtask

	// zero in every register acts as 1: one word per frame, then rows past the end
	task automatic test_zero_regs();
		set_geometry(0, 0, 0, 0);
		send_pixel({1'b1, 32'hFFFF_FFFF});
		send_pixel(rand_pixel(1'b0));
		send_pixel(rand_pixel(1'b0));
		send_pixel({1'b1, 32'h0000_0000});
		send_pixel(rand_pixel(1'b1));
	endtask

	// out width beyond the source, trailing column and row dropped, restart mid frame
	task automatic test_partial_blocks();
		set_geometry(2, 5, 4, 2);
		send_frame(5, 5, 1'b1, 1'b1);
		send_frame(1, 3, 1'b1, 1'b0);
		send_frame(2, 5, 1'b1, 1'b0);
	endtask

	// register writes while a frame is open, only where every read slot was cleared
	task automatic test_midframe_changes();
		set_geometry(2, 6, 3, 4);
		send_frame(2, 6, 1'b1, 1'b0);
		// at a band boundary: new scale and width apply from the next word
		settle();
		write_reg(bfd_pkg::CFG_SCALE, 3);
		write_reg(bfd_pkg::CFG_OUT_WIDTH, 2);
		send_frame(3, 6, 1'b0, 1'b1);
		// part way along the top row of a band, shrink the width below the column counter
		send_frame(1, 4, 1'b0, 1'b0);
		settle();
		write_reg(bfd_pkg::CFG_SRC_WIDTH, 3);
		send_frame(1, 7, 1'b0, 1'b0);
		// height lowered to the current band: the rest of the frame is dropped
		settle();
		write_reg(bfd_pkg::CFG_OUT_HEIGHT, 3);
		send_frame(1, 3, 1'b0, 1'b0);
		send_frame(3, 3, 1'b1, 1'b1);
	endtask

	// values past the limits saturate
	task automatic test_saturation();
		// scale clamps to 64: one row fills slots 0 and 1 with 64 words each,
		// then scale 2 closes both slots on the next row
		set_geometry(127, 130, 2, 1);
		send_frame(1, 130, 1'b1, 1'b1);
		settle();
		write_reg(bfd_pkg::CFG_SCALE, 2);
		send_frame(1, 4, 1'b0, 1'b0);
		// out width clamps to 128: last column 127, the two after it dropped
		set_geometry(1, 8191, 255, 2);
		send_frame(1, 130, 1'b1, 1'b0);
		// height clamps to 128: one word per row, last row 127
		set_geometry(1, 1, 1, 255);
		send_frame(130, 1, 1'b1, 1'b0);
	endtask

	// random small geometries, mostly whole frames, some cut short or restarted
	task automatic test_random_frames();
		int unsigned sent, pick, s, s_eff, fit, sw, ow, oh, oh_eff, rows, total;
		bit          keep, fresh;
		sent = 0;
		while (sent < RAND_WORDS) begin
			keep = (sent != 0) && ($urandom_range(0, 2) == 0);
			if (!keep) begin
				pick = $urandom_range(0, 15);
				if (pick <= 5) begin
					s = 1;
				end else if (pick <= 9) begin
					s = 2;
				end else if (pick <= 12) begin
					s = 3;
				end else if (pick == 13) begin
					s = 4;
				end else if (pick == 14) begin
					s = $urandom_range(5, 8);
				end else begin
					s = 0;
				end
				s_eff = (s == 0) ? 1 : s;
				fit   = (s_eff > 4) ? $urandom_range(1, 2) : $urandom_range(1, 4);
				sw    = s_eff * fit + $urandom_range(0, s_eff - 1);
				case ($urandom_range(0, 3))
					0: begin
						ow = fit + $urandom_range(1, 3);
					end
					1: begin
						ow = $urandom_range(1, fit);
					end
					default: begin
						ow = fit;
					end
				endcase
				oh     = $urandom_range(0, 3);
				oh_eff = (oh == 0) ? 1 : oh;
				set_geometry(s, sw, ow, oh);
			end
			// a few rows past the last band
			rows  = oh_eff * s_eff + $urandom_range(0, s_eff);
			total = rows * sw;
			if (total > 400) begin
				total = 400;
			end
			// broken frame, cut off anywhere
			if ($urandom_range(0, 5) == 0) begin
				total = $urandom_range(1, total);
			end
			calm  = (sent >= RAND_WORDS * 4 / 5) || ($urandom_range(0, 3) == 0);
			// with unchanged registers the walk may simply carry on
			fresh = !keep || ($urandom_range(0, 7) != 0);
			for (int n = 0; n < total; n++) begin
				send_pixel(rand_pixel((n == 0 && fresh) || $urandom_range(0, 63) == 0));
				sent++;
			end
		end
	endtask

	// result side stalls in random bursts, none started while calm is set
	always @(negedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			res_ready  <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 11);
			res_ready  <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// every accepted averaged word against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (thumb_q.size() == 0) begin
				$error("averaged word with none owed: x %0d y %0d", res.out_x, res.out_y);
				fail_count++;
			end else begin
				due_word = thumb_q.pop_front();
				check_field("out_x", 8'(due_word.out_x), 8'(res.out_x));
				check_field("out_y", 8'(due_word.out_y), 8'(res.out_y));
				check_field("avg_blue", due_word.avg_blue, res.avg_blue);
				check_field("avg_green", due_word.avg_green, res.avg_green);
				check_field("avg_red", due_word.avg_red, res.avg_red);
				check_field("avg_alpha", due_word.avg_alpha, res.avg_alpha);
				check_field("frame_last", 8'(due_word.frame_last), 8'(res.frame_last));
			end
		end
	end

	// hang detector: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("** box_filter_image_downscaler: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix       = '0;
		cfg_valid = 1'b0;
		cfg_index = bfd_pkg::CFG_SCALE;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_zero_regs();
		test_partial_blocks();
		test_midframe_changes();
		test_saturation();
		test_random_frames();

		// drain, then watch a while for stray words
		pix_valid <= 1'b0;
		while (thumb_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC * 2) @(negedge clk);
		if (fail_count == 0) begin
			$display("** box_filter_image_downscaler: PASSED **");
		end else begin
			$display("** box_filter_image_downscaler: FAILED **");
		end
		$finish;
	end

endmodule
